// ===== design/sliding_window_replay_check_macros.svh =====
// ----------------------------------------------------------------------------
// sliding window replay check assertion macros
// shared assertion forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_REPLAY_CHECK_MACROS_SVH
`define SLIDING_WINDOW_REPLAY_CHECK_MACROS_SVH

// consequent checked in the same cycle
`define SWRC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swrc same-cycle check failed");

// consequent checked in the next cycle
`define SWRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swrc next-cycle check failed");

`endif

// ===== design/swrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc package
// status codes, transaction payloads and register map of the replay checker
// ----------------------------------------------------------------------------
package swrc_pkg;

	localparam int DATA_W     = 32;
	localparam int CFG_ADDR_W = 3;

	// register map, index is paddr[CFG_ADDR_W-1:2]
	localparam logic [CFG_ADDR_W-3:0] REG_EXPIRE_INTERVAL = '0;
	localparam logic [DATA_W-1:0] EXPIRE_INTERVAL_RESET = 32'd30000;

	typedef enum logic [2:0] {
		ST_ACCEPT     = 3'd0,
		ST_ID_ZERO    = 3'd1,
		ST_EPOCH_BACK = 3'd2,
		ST_REPLAY     = 3'd3,
		ST_EXPIRED    = 3'd4,
		ST_TOO_OLD    = 3'd5
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0] packet_id;
		logic [DATA_W-1:0] packet_epoch;
		logic [DATA_W-1:0] now_ticks;
	} pkt_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] largest_backtrack;
	} res_t;

endpackage

// ===== design/swrc_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc stream interface
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface swrc_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/swrc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module swrc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/sliding_window_replay_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding window replay check
// anti-replay checker: one packet transaction in on pkt, one verdict out on res
// pkt carries packet_id, packet_epoch and now_ticks; res carries status and
// largest_backtrack. expire_interval is written over the apb port at byte 0.
// the seen bits live in a WINDOW_SIZE x 1 ram, the scalar window state in flops.
// each packet is accepted in idle, then passes prep (id zero, epoch and expiry
// checks) and step; id zero and an old epoch go straight to done. a forward
// step writes the new id's bit and, for a step of more than one id, goes
// through clear (one ram write a cycle clears the skipped ids); a jump of a
// whole window or more clears all but the new base entry. a backtrack rejected
// as too old or expired goes to done from step; one that reaches the ram reads
// in step, then checks in check and sets its bit if unseen. done loads the output register.
// after reset the ram is swept to zero, all WINDOW_SIZE entries, with pkt.ready
// low; apb writes are taken throughout.
// a stalled receiver holds the result register; the next packet is still taken
// and worked on, and waits at its end until the output register is free.
// ----------------------------------------------------------------------------
module sliding_window_replay_check #(
	parameter int WINDOW_SIZE = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	swrc_stream_if.sink                         pkt,
	swrc_stream_if.source                       res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swrc_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [swrc_pkg::DATA_W-1:0]         pwdata,
	output logic [swrc_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);
	localparam int AW = $clog2(WINDOW_SIZE);
	localparam logic [AW:0] WIN_FULL = (AW+1)'(WINDOW_SIZE);
	localparam int DW = swrc_pkg::DATA_W;

	typedef enum logic [6:0] {
		S_INIT  = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_PREP  = 7'b0000100,
		S_STEP  = 7'b0001000,
		S_CLEAR = 7'b0010000,
		S_CHECK = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// captured transaction
	logic [DW-1:0] pid_q, epoch_q, now_q;

	// window state
	logic [AW-1:0] base_q;
	logic [AW:0]   ext_q;
	logic [DW-1:0] highest_q, cur_epoch_q, floor_q, expire_time_q, max_bt_q;
	logic [DW-1:0] interval_q;

	// sequencing
	logic [AW-1:0] clr_addr_q, clr_cnt_q, slot_q;
	swrc_pkg::status_t status_q;

	// output register
	logic              res_valid_q;
	swrc_pkg::status_t res_status_q;
	logic [DW-1:0]     res_bt_q;

	// ram ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [0:0]    ram_wdata, ram_rdata;

	swrc_ram #(
		.WIDTH (1),
		.DEPTH (WINDOW_SIZE)
	) u_seen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------------
	// apb register port
	// ------------------------------------------------------------------------
	logic cfg_sel;
	assign cfg_sel = (paddr[swrc_pkg::CFG_ADDR_W-1:2] == swrc_pkg::REG_EXPIRE_INTERVAL);
	assign pready  = 1'b1;
	assign prdata  = cfg_sel ? interval_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= swrc_pkg::EXPIRE_INTERVAL_RESET;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			interval_q <= pwdata;
		end
	end

	// ------------------------------------------------------------------------
	// prep stage: expiry, id zero and epoch checks
	// ------------------------------------------------------------------------
	logic [DW-1:0] age;
	logic          expiry_hit;
	logic [DW-1:0] floor_e;
	assign age        = now_q - expire_time_q;
	assign expiry_hit = ~age[DW-1];   // wrap-safe: now at or past expiry
	assign floor_e    = expiry_hit ? highest_q : floor_q;

	// ------------------------------------------------------------------------
	// step stage: forward move or backtrack lookup
	// ------------------------------------------------------------------------
	logic          fwd, near;
	logic [DW-1:0] d_fwd, d_back;
	logic [AW-1:0] new_base, clr_count, slot;
	logic [AW:0]   ext_sum, ext_new;
	logic          too_old, below_floor;

	assign fwd      = pid_q > highest_q;
	assign d_fwd    = pid_q - highest_q;
	assign d_back   = highest_q - pid_q;
	assign near     = (d_fwd[DW-1:AW] == '0);
	// a jump of a whole window restarts at base zero and clears everything else
	assign new_base  = near ? (base_q - d_fwd[AW-1:0]) : '0;
	assign clr_count = near ? (d_fwd[AW-1:0] - AW'(1)) : '1;
	assign ext_sum   = ext_q + {1'b0, d_fwd[AW-1:0]};
	assign ext_new   = (!near || ext_sum > WIN_FULL) ? WIN_FULL : ext_sum;
	assign too_old     = d_back >= DW'(ext_q);
	assign below_floor = pid_q <= floor_q;
	assign slot        = base_q + d_back[AW-1:0];

	// ------------------------------------------------------------------------
	// ram port muxing; accesses are sequenced so a read never meets a write
	// to the same entry in flight
	// ------------------------------------------------------------------------
	assign ram_raddr = slot;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = 1'b0;
		unique case (state_q)
			S_INIT, S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_STEP: begin
				if (fwd) begin
					ram_we    = 1'b1;
					ram_waddr = new_base;
					ram_wdata = 1'b1;
				end
			end
			S_CHECK: begin
				if (!ram_rdata[0]) begin
					ram_we    = 1'b1;
					ram_waddr = slot_q;
					ram_wdata = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// handshakes
	// ------------------------------------------------------------------------
	logic out_free;
	assign out_free  = !res_valid_q || res.ready;
	assign pkt.ready = (state_q == S_IDLE);
	assign res.valid = res_valid_q;
	assign res.data  = '{status: res_status_q, largest_backtrack: res_bt_q};

	// captured fields need no reset
	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			pid_q   <= pkt.data.packet_id;
			epoch_q <= pkt.data.packet_epoch;
			now_q   <= pkt.data.now_ticks;
		end
		if (state_q == S_STEP) begin
			slot_q <= slot;
		end
	end

	// result valid: loaded from the done state, dropped when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// sequencer and window state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			base_q        <= '0;
			ext_q         <= '0;
			highest_q     <= '0;
			cur_epoch_q   <= '0;
			floor_q       <= '0;
			expire_time_q <= '0;
			max_bt_q      <= '0;
			clr_addr_q    <= '0;
			clr_cnt_q     <= '0;
			status_q      <= swrc_pkg::ST_ACCEPT;
			res_status_q  <= swrc_pkg::ST_ACCEPT;
			res_bt_q      <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					// power-up sweep of the seen bits
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pkt.valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (pid_q == '0) begin
						floor_q  <= floor_e;
						status_q <= swrc_pkg::ST_ID_ZERO;
						state_q  <= S_DONE;
					end else if (epoch_q > cur_epoch_q) begin
						// newer epoch restarts the window, seen bits stay
						base_q      <= '0;
						ext_q       <= '0;
						highest_q   <= '0;
						floor_q     <= '0;
						cur_epoch_q <= epoch_q;
						state_q     <= S_STEP;
					end else if (epoch_q < cur_epoch_q) begin
						floor_q  <= floor_e;
						status_q <= swrc_pkg::ST_EPOCH_BACK;
						state_q  <= S_DONE;
					end else begin
						floor_q <= floor_e;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (fwd) begin
						// new id's bit is written by the ram mux this cycle
						base_q        <= new_base;
						ext_q         <= ext_new;
						highest_q     <= pid_q;
						expire_time_q <= now_q + interval_q;
						status_q      <= swrc_pkg::ST_ACCEPT;
						clr_addr_q    <= new_base + AW'(1);
						clr_cnt_q     <= clr_count;
						state_q       <= (clr_count == '0) ? S_DONE : S_CLEAR;
					end else begin
						if (d_back > max_bt_q) begin
							max_bt_q <= d_back;
						end
						priority if (too_old) begin
							status_q <= swrc_pkg::ST_TOO_OLD;
							state_q  <= S_DONE;
						end else if (below_floor) begin
							status_q <= swrc_pkg::ST_EXPIRED;
							state_q  <= S_DONE;
						end else begin
							// ram read of the slot is under way
							state_q <= S_CHECK;
						end
					end
				end
				S_CLEAR: begin
					// one skipped id cleared per cycle
					clr_addr_q <= clr_addr_q + AW'(1);
					clr_cnt_q  <= clr_cnt_q - AW'(1);
					if (clr_cnt_q == AW'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_CHECK: begin
					if (ram_rdata[0]) begin
						status_q <= swrc_pkg::ST_REPLAY;
					end else begin
						status_q      <= swrc_pkg::ST_ACCEPT;
						expire_time_q <= now_q + interval_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hand the verdict to the output register once it is free
					if (out_free) begin
						res_status_q <= status_q;
						res_bt_q     <= max_bt_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== design/swrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc port checker
// port-level properties of the replay checker, bound to the top level
// ----------------------------------------------------------------------------
`include "sliding_window_replay_check_macros.svh"

module swrc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pkt_valid,
	input  logic                        pkt_ready,
	input  logic                        res_valid,
	input  logic                        res_ready,
	input  swrc_pkg::status_t           res_status,
	input  logic [swrc_pkg::DATA_W-1:0] res_largest_backtrack
);
	logic pkt_take;
	assign pkt_take = pkt_valid && pkt_ready;

	// a stalled result holds
	`SWRC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_largest_backtrack))

	// one packet in work at a time
	`SWRC_ASSERT_NEXT(a_one_in_flight, pkt_take, !pkt_ready)

	// no verdict can appear the cycle right after a packet is taken
	`SWRC_ASSERT_NEXT(a_min_latency, pkt_take, !$rose(res_valid))

	// while idle the result register is left alone
	`SWRC_ASSERT_NEXT(a_idle_quiet, pkt_ready, $stable(res_status) && $stable(res_largest_backtrack))
endmodule

bind sliding_window_replay_check swrc_checker u_swrc_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.pkt_valid             (pkt.valid),
	.pkt_ready             (pkt.ready),
	.res_valid             (res.valid),
	.res_ready             (res.ready),
	.res_status            (res.data.status),
	.res_largest_backtrack (res.data.largest_backtrack)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding window replay check testbench
// drives packet transactions into the replay checker and holds a transaction-level
// mirror of its window state. every verdict that comes back is compared with
// the mirror's prediction. expire_interval is moved through several settings
// between phases over the apb port, and both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import swrc_pkg::*;

	localparam int          CLK_PERIOD   = 8;
	localparam int          WINDOW       = 256;
	localparam int          WIN_BITS     = $clog2(WINDOW);
	localparam int          N_PHASES     = 7;
	localparam int          PHASE_ITEMS  = 190;
	localparam int          TAIL_CYCLES  = 300;
	localparam int unsigned LIMIT_CYCLES = 2_000_000;

	// index with no register behind it, writes there must change nothing
	localparam logic [CFG_ADDR_W-3:0] REG_SPARE = 1'b1;

	// expire_interval per phase, with the tick advance per packet to match
	localparam int unsigned PHASE_INTERVAL [N_PHASES] = '{
		32'd0, 32'd20, 32'd500, 32'hFFFF_FFFF, 32'd30000, 32'h7FFF_FFFF, 32'd64
	};
	localparam int unsigned PHASE_SPAN [N_PHASES] = '{
		16, 12, 40, 16, 3000, 16, 24
	};

	// mirror of the checker: window bits, scalar state and expected verdicts
	class window_mirror;
		bit                  seen [WINDOW];
		logic [WIN_BITS-1:0] base;
		logic [WIN_BITS:0]   extent;
		logic [DATA_W-1:0]   highest_id;
		logic [DATA_W-1:0]   current_epoch;
		logic [DATA_W-1:0]   floor_mark;
		logic [DATA_W-1:0]   expire_time;
		logic [DATA_W-1:0]   peak_backtrack;
		logic [DATA_W-1:0]   expire_interval;
		res_t                verdict_q [$];
		int unsigned         mismatches;
		int unsigned         n_checked;

		function new();
			foreach (seen[i]) seen[i] = 1'b0;
			base            = '0;
			extent          = '0;
			highest_id      = '0;
			current_epoch   = '0;
			floor_mark      = '0;
			expire_time     = '0;
			peak_backtrack  = '0;
			expire_interval = EXPIRE_INTERVAL_RESET;
			mismatches      = 0;
			n_checked       = 0;
		endfunction

		function void set_expire_interval(logic [DATA_W-1:0] value);
			expire_interval = value;
		endfunction

		function int unsigned pending();
			return verdict_q.size();
		endfunction

		// accepted packet: update the window and queue the verdict it earns
		function void note_packet(pkt_t p);
			status_t             st;
			logic [DATA_W-1:0]   d;
			logic [WIN_BITS-1:0] slot;
			res_t                want;
			st = ST_ACCEPT;
			// expiry is evaluated first, even for packets rejected later
			if ($signed(p.now_ticks - expire_time) >= 0)
				floor_mark = highest_id;
			if (p.packet_id == '0) begin
				st = ST_ID_ZERO;
			end else if (p.packet_epoch < current_epoch) begin
				st = ST_EPOCH_BACK;
			end else begin
				if (p.packet_epoch > current_epoch) begin
					// new epoch restarts the window, bits and backtrack stay
					base          = '0;
					extent        = '0;
					highest_id    = '0;
					floor_mark    = '0;
					current_epoch = p.packet_epoch;
				end
				if (p.packet_id > highest_id) begin
					d = p.packet_id - highest_id;
					if (d < WINDOW) begin
						base       = base - d[WIN_BITS-1:0];
						seen[base] = 1'b1;
						for (int i = 1; i < d; i++) begin
							slot       = base + i[WIN_BITS-1:0];
							seen[slot] = 1'b0;
						end
						extent = (extent + d > WINDOW) ? WINDOW[WIN_BITS:0] : extent + d[WIN_BITS:0];
					end else begin
						foreach (seen[i]) seen[i] = 1'b0;
						base    = '0;
						extent  = WINDOW[WIN_BITS:0];
						seen[0] = 1'b1;
					end
					highest_id = p.packet_id;
				end else begin
					d = highest_id - p.packet_id;
					if (d > peak_backtrack)
						peak_backtrack = d;
					slot = base + d[WIN_BITS-1:0];
					if (d >= extent)
						st = ST_TOO_OLD;
					else if (p.packet_id <= floor_mark)
						st = ST_EXPIRED;
					else if (seen[slot])
						st = ST_REPLAY;
					else
						seen[slot] = 1'b1;
				end
				if (st == ST_ACCEPT)
					expire_time = p.now_ticks + expire_interval;
			end
			want.status            = st;
			want.largest_backtrack = peak_backtrack;
			verdict_q.push_back(want);
		endfunction

		// returned verdict against the oldest prediction
		function void check_verdict(res_t got);
			res_t want;
			n_checked++;
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("verdict %0d with nothing pending: status %0d backtrack %0d",
						n_checked, got.status, got.largest_backtrack);
				return;
			end
			want = verdict_q.pop_front();
			if (got.status !== want.status ||
				got.largest_backtrack !== want.largest_backtrack) begin
				mismatches++;
				if (mismatches <= 10)
					$display("verdict %0d: status exp %0d got %0d, backtrack exp %0d got %0d",
						n_checked, want.status, got.status,
						want.largest_backtrack, got.largest_backtrack);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	swrc_stream_if #(.data_t(pkt_t)) pkt_if ();
	swrc_stream_if #(.data_t(res_t)) res_if ();

	window_mirror      sb;
	bit                calm;       // no idling on either side while set
	logic [DATA_W-1:0] tick;       // running tick count for generated packets
	int unsigned       tick_span;  // usual bound on the tick advance per packet, rare huge jumps aside
	int unsigned       cycles;

	sliding_window_replay_check #(
		.WINDOW_SIZE(WINDOW)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_if),
		.res    (res_if),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// one packet transaction, valid raised at a falling edge after a gap
	task automatic send_packet(input pkt_t p);
		int unsigned gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			pkt_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pkt_if.valid <= 1'b1;
		pkt_if.data  <= p;
		@(posedge clk);
		while (!pkt_if.ready) @(posedge clk);
		sb.note_packet(p);
	endtask

	// drop valid and wait until every verdict has come back
	task automatic hold_until_drained();
		@(negedge clk);
		pkt_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// apb write, setup cycle then access cycle
	task automatic write_reg(input logic [CFG_ADDR_W-3:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_EXPIRE_INTERVAL)
			sb.set_expire_interval(value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random packet steered by the mirror state: mostly well-formed traffic
	// around the highest id, plus epoch changes, id zero and full noise
	function automatic pkt_t make_packet();
		pkt_t        p;
		int unsigned r;
		int unsigned bt;
		r = $urandom_range(0, 99);
		// rare huge tick jumps cross the wrap-safe expiry compare both ways
		if ($urandom_range(0, 99) < 3)
			tick = tick + $urandom;
		else
			tick = tick + $urandom_range(0, tick_span);
		p.packet_epoch = sb.current_epoch;
		p.now_ticks    = tick;
		p.packet_id    = sb.highest_id + 1;
		if (r < 30) begin
			// small forward step
			p.packet_id = sb.highest_id + $urandom_range(1, 8);
		end else if (r < 34) begin
			// long forward step, about half of them past the whole window
			p.packet_id = sb.highest_id + $urandom_range(9, 2 * WINDOW);
		end else if (r < 62) begin
			// backtrack inside the window, replays and fresh slots
			bt = $urandom_range(0, 40);
			p.packet_id = (sb.highest_id > bt) ? sb.highest_id - bt : sb.highest_id + 1;
		end else if (r < 70) begin
			// backtrack around the window edge
			bt = $urandom_range(WINDOW - 16, WINDOW + 16);
			p.packet_id = (sb.highest_id > bt) ? sb.highest_id - bt : sb.highest_id + 1;
		end else if (r < 74) begin
			p.packet_id = '0;
		end else if (r < 77) begin
			// later epoch, usually by one
			p.packet_epoch = sb.current_epoch +
				(($urandom_range(0, 3) == 0) ? $urandom_range(2, 1 << 20) : 1);
			p.packet_id = $urandom_range(1, 20);
		end else if (r < 80) begin
			// earlier epoch
			p.packet_epoch = (sb.current_epoch == 0) ? '0 :
				$urandom_range(0, sb.current_epoch - 1);
		end else if (r < 86) begin
			// noise on every field, epoch never ahead of the current one
			p.packet_id    = $urandom;
			p.now_ticks    = $urandom;
			p.packet_epoch = (r % 2) ? sb.current_epoch : $urandom_range(0, sb.current_epoch);
		end else begin
			// replay of the last few ids
			bt = $urandom_range(0, 3);
			p.packet_id = (sb.highest_id > bt) ? sb.highest_id - bt : sb.highest_id + 1;
		end
		return p;
	endfunction

	// receiver stalls, independent of the sender
	initial begin : res_backpressure
		int unsigned stall;
		stall = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall != 0) begin
				res_if.ready <= 1'b0;
				stall--;
			end else begin
				res_if.ready <= 1'b1;
				stall = calm ? 0 : pick_gap();
			end
		end
	end

	// every verdict transaction is checked at the edge that takes it
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_verdict(res_if.data);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("sliding_window_replay_check: mismatch");
			$finish;
		end
	end

	initial begin
		sb           = new();
		cycles       = 0;
		calm         = 1'b0;
		tick         = 32'd100;
		tick_span    = 16;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pkt_if.valid = 1'b0;
		pkt_if.data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at the reset interval of 30000 ticks
		send_packet('{32'd0, 32'd0, 32'd100});          // id zero
		send_packet('{32'd1, 32'd0, 32'd110});          // first forward step
		send_packet('{32'd1, 32'd0, 32'd120});          // replay of the highest id
		send_packet('{32'd5, 32'd0, 32'd130});          // skip three ids
		send_packet('{32'd3, 32'd0, 32'd140});          // fill a skipped slot
		send_packet('{32'd3, 32'd0, 32'd150});          // replay inside the window
		send_packet('{32'd300, 32'd0, 32'd160});        // jump past the window
		send_packet('{32'd45, 32'd0, 32'd170});         // deepest slot still inside
		send_packet('{32'd44, 32'd0, 32'd180});         // one past the window
		send_packet('{32'd555, 32'd0, 32'd190});        // forward by window minus one
		send_packet('{32'd811, 32'd0, 32'd200});        // forward by exactly the window
		send_packet('{32'd10, 32'd5, 32'd210});         // later epoch
		send_packet('{32'd11, 32'd4, 32'd220});         // earlier epoch
		send_packet('{32'd7, 32'd5, 32'd60000});        // expiry raises the floor
		send_packet('{32'd12, 32'd5, 32'd60010});       // forward after expiry
		send_packet('{32'd8, 32'd5, 32'd60020});        // at or below the floor
		send_packet('{32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFF0}); // top id, tick near wrap
		send_packet('{32'hFFFF_FFFE, 32'd5, 32'h0000_0010}); // tick wrapped, not yet expired
		send_packet('{32'h8000_0000, 32'd6, 32'h0000_8000}); // expiry then new epoch
		send_packet('{32'h7FFF_FFFF, 32'd6, 32'h0000_8010}); // backtrack by one
		send_packet('{32'h8000_0001, 32'd7, 32'h0000_8020}); // another epoch

		// write to the unmapped index changes nothing
		hold_until_drained();
		write_reg(REG_SPARE, $urandom);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			hold_until_drained();
			write_reg(REG_EXPIRE_INTERVAL, PHASE_INTERVAL[ph]);
			tick_span = PHASE_SPAN[ph];
			tick      = (ph == 3) ? 32'hFFFF_FC00 : $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stretches with no idling at all
				if (n % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				// sender now and then waits for the checker to empty
				if ($urandom_range(0, 199) == 0)
					hold_until_drained();
				if (ph == N_PHASES - 1 && n == PHASE_ITEMS / 2)
					send_packet('{$urandom_range(1, 32'hFFFF_FFFF), 32'hFFFF_FFFF, tick});
				else
					send_packet(make_packet());
			end
		end

		// drain, then let any late transaction show up
		calm = 1'b0;
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("sliding_window_replay_check: match");
		else
			$display("sliding_window_replay_check: mismatch");
		$finish;
	end

endmodule

// ===== sliding_window_replay_check.f =====
+incdir+design
design/swrc_pkg.sv
design/swrc_stream_if.sv
design/swrc_ram.sv
design/sliding_window_replay_check.sv
design/swrc_checker.sv
dv/tb_top.sv
